/* hw/rtl/swm_pkg.sv */
package swm_pkg;

    // window size register
    localparam int CFG_WIDTH = 7;
    localparam logic [CFG_WIDTH-1:0] CFG_RESET = 7'd3;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_EMIT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic remove;
        logic insert;
        logic emit;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic full;
        logic out_free;
    } t_status;

endpackage

/* hw/rtl/swm_ctrl.sv */
module swm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  swm_pkg::t_status i_status,
    output swm_pkg::t_cmd   o_cmd,
    output logic            o_stall
);
    import swm_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_status.full ? ST_REMOVE : ST_INSERT;
                end
            end
            ST_REMOVE: begin
                n_state = ST_INSERT;
            end
            ST_INSERT: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_status.full || i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            ST_REMOVE: begin
                o_cmd.remove = 1'b1;
            end
            ST_INSERT: begin
                o_cmd.insert = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.emit = i_status.full && i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* hw/rtl/swm_datapath.sv */
module swm_datapath #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [swm_pkg::CFG_WIDTH-1:0]  i_cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_stall,
    input  swm_pkg::t_cmd                  i_cmd,
    output swm_pkg::t_status               o_status,
    output logic                           o_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_median
);
    import swm_pkg::*;

    localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    logic [CFG_WIDTH-1:0]           r_window;
    logic [CNT_W-1:0]               r_count;
    logic [PTR_W-1:0]               r_ptr;
    logic signed [SAMPLE_WIDTH-1:0] r_key;
    logic signed [SAMPLE_WIDTH-1:0] r_old;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_median;

    logic signed [SAMPLE_WIDTH-1:0] r_ring [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] r_sorted [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] n_sorted [WINDOW_MAX];

    logic [WINDOW_MAX-1:0] w_gt;
    logic [WINDOW_MAX-1:0] w_ge;
    logic [31:0]           w_cfg_ext;
    logic [CNT_W-1:0]      w_k;
    logic [CNT_W-1:0]      w_ptr_inc;
    logic [CNT_W-1:0]      w_mid;

    // effective window length, clamped to one..WINDOW_MAX
    assign w_cfg_ext = 32'(r_window);
    always_comb begin
        if (w_cfg_ext == 32'd0) begin
            w_k = CNT_W'(1);
        end else if (w_cfg_ext > 32'(WINDOW_MAX)) begin
            w_k = CNT_W'(WINDOW_MAX);
        end else begin
            w_k = CNT_W'(w_cfg_ext);
        end
    end

    assign w_ptr_inc = CNT_W'(r_ptr) + CNT_W'(1);
    assign w_mid     = (w_k - CNT_W'(1)) >> 1;

    // status to the controller
    assign o_status.full     = (r_count == w_k);
    assign o_status.out_free = !r_out_valid || !i_stall;

    // per-cell compares against the stored order
    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cmp
        assign w_gt[g] = (CNT_W'(g) < r_count) && (r_sorted[g] > r_key);
        assign w_ge[g] = (r_sorted[g] >= r_old);
    end

    // compare-and-shift next values of the sorted row
    always_comb begin
        for (int i = 0; i < WINDOW_MAX; i++) begin
            n_sorted[i] = r_sorted[i];
            if (i_cmd.remove) begin
                // first entry not below the oldest sample is the one to drop
                if (i < WINDOW_MAX - 1) begin
                    if (w_ge[i]) begin
                        n_sorted[i] = r_sorted[i + 1];
                    end
                end
            end else if (i_cmd.insert) begin
                if (i > 0 && w_gt[(i > 0) ? i - 1 : 0]) begin
                    n_sorted[i] = r_sorted[(i > 0) ? i - 1 : 0];
                end else if (w_gt[i] || (CNT_W'(i) == r_count)) begin
                    n_sorted[i] = r_key;
                end
            end
        end
    end

    // sorted row
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < WINDOW_MAX; i++) begin
            r_sorted[i] <= n_sorted[i];
        end
    end

    // sample ring, registered read of the oldest slot on transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_old <= r_ring[r_ptr];
            r_key <= i_sample;
        end
        if (i_cmd.insert) begin
            r_ring[r_ptr] <= r_key;
        end
    end

    // window register, fill count and ring pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= CFG_RESET;
            r_count  <= '0;
            r_ptr    <= '0;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_data;
            r_count  <= '0;
            r_ptr    <= '0;
        end else if (i_cmd.remove) begin
            r_count <= r_count - CNT_W'(1);
        end else if (i_cmd.insert) begin
            r_count <= r_count + CNT_W'(1);
            if (w_ptr_inc >= w_k) begin
                r_ptr <= '0;
            end else begin
                r_ptr <= w_ptr_inc[PTR_W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_median <= r_sorted[w_mid[PTR_W-1:0]];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_median = r_median;

endmodule

/* hw/rtl/sliding_window_median_core.sv */
// sliding window median filter
// each accepted sample passes the controller's remove (once the window is full), insert
//   and emit steps over one compare-and-shift sorted row; no new sample is taken until
//   the last one is done, and a result is emitted only once the window is full
// synchronous active-low reset: window size 3, window empty, no result pending
module sliding_window_median_core #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [swm_pkg::CFG_WIDTH-1:0]  i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_median
);
    import swm_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // sequencing of one sample
    swm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_stall  (o_stall)
    );

    // ring, sorted row and output register
    swm_datapath #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_sample   (i_sample),
        .i_stall    (i_stall),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_valid    (o_valid),
        .o_median   (o_median)
    );

endmodule

/* hw/rtl/swm_checker.sv */
module swm_checker #(
    parameter int SAMPLE_WIDTH = 32
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    o_stall,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic [SAMPLE_WIDTH-1:0] o_median
);

    // nothing pending straight after reset
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a sample transfer makes the block busy
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after transfer");

    // a new result only appears while a sample is being worked on
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without a sample in progress");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_median)))
        else $error("stalled result changed");

endmodule

bind sliding_window_median_core swm_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_median (o_median)
);
